### hw/rtl/psa_pkg.sv
// psa_pkg: shared types, widths, register map and reset values for the
// pixel saturation adjust pipeline. No dependencies.
package psa_pkg;

  localparam int CH_W     = 8;
  localparam int FACTOR_W = 10;
  localparam int WEIGHT_W = 9;
  localparam int NUM_CH   = 3;

  // luma products and sum
  localparam int LPROD_W = CH_W + WEIGHT_W;   // 17
  localparam int LSUM_W  = LPROD_W + 2;       // 19
  // chroma gain product: signed 9-bit diff times 11-bit signed factor
  localparam int GPROD_W = 19;
  // coverage blend product: signed 9-bit diff times 9-bit signed coverage
  localparam int BPROD_W = 17;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_FACTOR   = 2'd0;
  localparam logic [1:0] REG_WEIGHT_R = 2'd1;
  localparam logic [1:0] REG_WEIGHT_G = 2'd2;
  localparam logic [1:0] REG_WEIGHT_B = 2'd3;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET   = 10'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_R_RESET = 9'd77;
  localparam logic [WEIGHT_W-1:0] WEIGHT_G_RESET = 9'd150;
  localparam logic [WEIGHT_W-1:0] WEIGHT_B_RESET = 9'd29;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // channel 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    pix_t            pix;
    logic [CH_W-1:0] cov;
    logic            masked;
  } item_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [WEIGHT_W-1:0] weight_r;
    logic [WEIGHT_W-1:0] weight_g;
    logic [WEIGHT_W-1:0] weight_b;
  } cfg_t;

endpackage

### hw/rtl/pixel_saturation_adjust.sv
// pixel_saturation_adjust: top level; luma, chroma gain and coverage blend
// pipeline plus configuration registers. Depends on psa_pkg and all psa_* modules.
//
// Takes one RGB pixel and returns one adjusted pixel per clock while out_stall
// is low. A pixel passes two stages of luma (weight products, then sum and clamp),
// two of chroma gain (multiply, then shift/add/clamp) and two of coverage blend
// (multiply, then add or bypass into the output register). Each stage holds its
// own valid bit; out_stall backs up through the stages combinationally, so
// in_stall rises only when every stage is full. The user must write registers
// through the APB port while the pipe is empty; the block does not enforce it.
module pixel_saturation_adjust import psa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // pixel input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CH_W-1:0]    red_in,
  input  logic [CH_W-1:0]    green_in,
  input  logic [CH_W-1:0]    blue_in,
  input  logic [CH_W-1:0]    coverage,
  input  logic               masked_mode,
  // pixel output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    red_out,
  output logic [CH_W-1:0]    green_out,
  output logic [CH_W-1:0]    blue_out
);

  cfg_t            cfg;
  item_t           in_item;
  logic            in_ready;
  logic            l_valid, l_ready;
  item_t           l_item;
  logic [CH_W-1:0] l_lum;
  logic            g_valid, g_ready;
  item_t           g_item;
  pix_t            g_adj;
  pix_t            o_pix;

  assign in_item.pix[0] = red_in;
  assign in_item.pix[1] = green_in;
  assign in_item.pix[2] = blue_in;
  assign in_item.cov    = coverage;
  assign in_item.masked = masked_mode;
  assign in_stall       = ~in_ready;

  psa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psa_luma u_luma (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (l_valid),
    .dn_ready (l_ready),
    .dn_item  (l_item),
    .dn_lum   (l_lum)
  );

  psa_gain u_gain (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (l_valid),
    .up_ready (l_ready),
    .up_item  (l_item),
    .up_lum   (l_lum),
    .dn_valid (g_valid),
    .dn_ready (g_ready),
    .dn_item  (g_item),
    .dn_adj   (g_adj)
  );

  psa_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .up_valid (g_valid),
    .up_ready (g_ready),
    .up_item  (g_item),
    .up_adj   (g_adj),
    .dn_valid (out_valid),
    .dn_ready (~out_stall),
    .dn_pix   (o_pix)
  );

  assign red_out   = o_pix[0];
  assign green_out = o_pix[1];
  assign blue_out  = o_pix[2];

endmodule

### hw/rtl/psa_regs.sv
// psa_regs: APB-style configuration registers (factor and luma weights).
// Depends on psa_pkg.
module psa_regs import psa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.factor   <= FACTOR_RESET;
      cfg.weight_r <= WEIGHT_R_RESET;
      cfg.weight_g <= WEIGHT_G_RESET;
      cfg.weight_b <= WEIGHT_B_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FACTOR:   cfg.factor   <= pwdata[FACTOR_W-1:0];
        REG_WEIGHT_R: cfg.weight_r <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_G: cfg.weight_g <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_B: cfg.weight_b <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FACTOR:   prdata = {{(PDATA_W-FACTOR_W){1'b0}}, cfg.factor};
      REG_WEIGHT_R: prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, cfg.weight_r};
      REG_WEIGHT_G: prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, cfg.weight_g};
      REG_WEIGHT_B: prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, cfg.weight_b};
      default:      prdata = '0;
    endcase
  end

endmodule

### hw/rtl/psa_luma.sv
// psa_luma: two pipeline stages computing the saturated 8-bit luma from Q1.8 weights.
// Stage a: weight products; stage b: sum, shift, clamp. Depends on psa_pkg.
module psa_luma import psa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  item_t           up_item,
  output logic            dn_valid,
  input  logic            dn_ready,
  output item_t           dn_item,
  output logic [CH_W-1:0] dn_lum
);

  logic               a_valid;
  item_t              a_item;
  logic [LPROD_W-1:0] a_pr, a_pg, a_pb;
  logic               b_valid;
  logic               a_ready, b_ready;
  logic [LSUM_W-1:0]  sum;
  logic [LSUM_W-9:0]  lum_full;
  logic [CH_W-1:0]    lum;

  assign b_ready  = ~b_valid | dn_ready;
  assign a_ready  = ~a_valid | b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (a_ready) a_valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_item <= up_item;
      a_pr   <= LPROD_W'(cfg.weight_r * up_item.pix[0]);
      a_pg   <= LPROD_W'(cfg.weight_g * up_item.pix[1]);
      a_pb   <= LPROD_W'(cfg.weight_b * up_item.pix[2]);
    end
  end

  assign sum      = LSUM_W'(a_pr) + LSUM_W'(a_pg) + LSUM_W'(a_pb);
  assign lum_full = sum[LSUM_W-1:8];
  // weights summing above 256 can push luma past 255
  assign lum      = (|lum_full[LSUM_W-9:CH_W]) ? CH_MAX : lum_full[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (b_ready) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      dn_item <= a_item;
      dn_lum  <= lum;
    end
  end

  assign dn_valid = b_valid;

endmodule

### hw/rtl/psa_gain.sv
// psa_gain: two pipeline stages applying the chroma gain around luma.
// Stage a: (c - lum) * factor; stage b: shift, add luma, clamp. Depends on psa_pkg.
module psa_gain import psa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  item_t           up_item,
  input  logic [CH_W-1:0] up_lum,
  output logic            dn_valid,
  input  logic            dn_ready,
  output item_t           dn_item,
  output pix_t            dn_adj
);

  logic                      a_valid;
  item_t                     a_item;
  logic [CH_W-1:0]           a_lum;
  logic signed [GPROD_W-1:0] a_prod [NUM_CH];
  logic                      b_valid;
  logic                      a_ready, b_ready;
  logic signed [CH_W:0]      diff [NUM_CH];
  logic signed [GPROD_W-1:0] prod [NUM_CH];
  logic signed [CH_W+3:0]    acc  [NUM_CH];
  logic signed [CH_W+2:0]    shr  [NUM_CH];
  pix_t                      adj;

  assign b_ready  = ~b_valid | dn_ready;
  assign a_ready  = ~a_valid | b_ready;
  assign up_ready = a_ready;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      diff[i] = $signed({1'b0, up_item.pix[i]}) - $signed({1'b0, up_lum});
      prod[i] = diff[i] * $signed({1'b0, cfg.factor});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (a_ready) a_valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_item <= up_item;
      a_lum  <= up_lum;
      for (int i = 0; i < NUM_CH; i++) a_prod[i] <= prod[i];
    end
  end

  // floor shift is taking the upper bits; then clamp to 0..255
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      shr[i] = a_prod[i][GPROD_W-1:8];
      acc[i] = $signed({4'b0000, a_lum}) + $signed({shr[i][CH_W+2], shr[i]});
      if (acc[i][CH_W+3])
        adj[i] = '0;
      else if (|acc[i][CH_W+2:CH_W])
        adj[i] = CH_MAX;
      else
        adj[i] = acc[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (b_ready) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      dn_item <= a_item;
      dn_adj  <= adj;
    end
  end

  assign dn_valid = b_valid;

endmodule

### hw/rtl/psa_blend.sv
// psa_blend: two stages; the second is the output register. In masked mode the
// adjusted pixel is blended with the original by coverage. Depends on psa_pkg.
module psa_blend import psa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  item_t up_item,
  input  pix_t  up_adj,
  output logic  dn_valid,
  input  logic  dn_ready,
  output pix_t  dn_pix
);

  logic                      a_valid;
  item_t                     a_item;
  pix_t                      a_adj;
  logic signed [BPROD_W-1:0] a_prod [NUM_CH];
  logic                      b_valid;
  logic                      a_ready, b_ready;
  logic signed [CH_W:0]      diff [NUM_CH];
  logic signed [BPROD_W-1:0] prod [NUM_CH];
  logic signed [CH_W:0]      shr  [NUM_CH];
  pix_t                      res;

  assign b_ready  = ~b_valid | dn_ready;
  assign a_ready  = ~a_valid | b_ready;
  assign up_ready = a_ready;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      diff[i] = $signed({1'b0, up_adj[i]}) - $signed({1'b0, up_item.pix[i]});
      prod[i] = diff[i] * $signed({1'b0, up_item.cov});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (a_ready) a_valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_item <= up_item;
      a_adj  <= up_adj;
      for (int i = 0; i < NUM_CH; i++) a_prod[i] <= prod[i];
    end
  end

  // in masked mode the result lies between c and adj, so 8-bit wraparound is exact,
  // and zero coverage gives the original pixel; otherwise adj passes through
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      shr[i] = a_prod[i][BPROD_W-1:8];
      if (a_item.masked)
        res[i] = a_item.pix[i] + shr[i][CH_W-1:0];
      else
        res[i] = a_adj[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (b_ready) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) dn_pix <= res;
  end

  assign dn_valid = b_valid;

endmodule

### tb/psa_check.sv
// psa_check: watches the pixel channels and register port of
// pixel_saturation_adjust, predicts every output pixel and register read
// and compares them. Depends on psa_pkg.
`timescale 1ns / 100ps

module psa_check import psa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CH_W-1:0]    red_in,
  input  logic [CH_W-1:0]    green_in,
  input  logic [CH_W-1:0]    blue_in,
  input  logic [CH_W-1:0]    coverage,
  input  logic               masked_mode,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CH_W-1:0]    red_out,
  input  logic [CH_W-1:0]    green_out,
  input  logic [CH_W-1:0]    blue_out,
  output int                 fail_count,
  output int                 pixels_in_flight
);

  cfg_t  cfg_shadow;
  pix_t  pixels_due[$];
  int    n_fail = 0;
  int    n_due = 0;
  string ch_name[NUM_CH] = '{"red", "green", "blue"};

  assign fail_count = n_fail;
  assign pixels_in_flight = n_due;

  task automatic report_mismatch(input string msg);
    $display("%0t psa_check: %s", $time, msg);
    n_fail++;
  endtask

  // gain the distance from luma, clamp, then in masked mode blend back by coverage
  function automatic logic [CH_W-1:0] tone_channel(int c, int lum, int cov, logic masked);
    int gain;
    int adj;
    int mixed;
    gain = int'(cfg_shadow.factor);
    adj = lum + (((c - lum) * gain) >>> 8);
    if (adj < 0) begin
      adj = 0;
    end else if (adj > int'(CH_MAX)) begin
      adj = int'(CH_MAX);
    end
    if (!masked) begin
      return adj[CH_W-1:0];
    end
    mixed = c + (((adj - c) * cov) >>> 8);
    return mixed[CH_W-1:0];
  endfunction

  function automatic pix_t saturate_pixel(item_t px);
    pix_t res;
    int   wr;
    int   wg;
    int   wb;
    int   lum;
    wr = int'(cfg_shadow.weight_r);
    wg = int'(cfg_shadow.weight_g);
    wb = int'(cfg_shadow.weight_b);
    // zero coverage in masked mode leaves the pixel untouched
    if (px.masked && px.cov == 0) begin
      return px.pix;
    end
    lum = (wr * int'(px.pix[0]) + wg * int'(px.pix[1]) + wb * int'(px.pix[2])) >>> 8;
    if (lum > int'(CH_MAX)) begin
      lum = int'(CH_MAX);
    end
    for (int i = 0; i < NUM_CH; i++) begin
      res[i] = tone_channel(int'(px.pix[i]), lum, int'(px.cov), px.masked);
    end
    return res;
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_FACTOR:   return PDATA_W'(cfg_shadow.factor);
      REG_WEIGHT_R: return PDATA_W'(cfg_shadow.weight_r);
      REG_WEIGHT_G: return PDATA_W'(cfg_shadow.weight_g);
      REG_WEIGHT_B: return PDATA_W'(cfg_shadow.weight_b);
      default:      return '0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    item_t px;
    pix_t  want;
    pix_t  got;
    if (rst) begin
      cfg_shadow.factor   <= FACTOR_RESET;
      cfg_shadow.weight_r <= WEIGHT_R_RESET;
      cfg_shadow.weight_g <= WEIGHT_G_RESET;
      cfg_shadow.weight_b <= WEIGHT_B_RESET;
      pixels_due.delete();
      n_due <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          // upper data bits beyond each register's width are dropped
          case (paddr[PADDR_W-1:2])
            REG_FACTOR:   cfg_shadow.factor   <= pwdata[FACTOR_W-1:0];
            REG_WEIGHT_R: cfg_shadow.weight_r <= pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_G: cfg_shadow.weight_g <= pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_B: cfg_shadow.weight_b <= pwdata[WEIGHT_W-1:0];
            default: ;
          endcase
        end else if (prdata != reg_value(paddr[PADDR_W-1:2])) begin
          report_mismatch($sformatf("register %0d read %0d, expected %0d",
                                    paddr[PADDR_W-1:2], prdata,
                                    reg_value(paddr[PADDR_W-1:2])));
        end
      end

      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          report_mismatch("output transfer with no pixel expected");
        end else begin
          want = pixels_due.pop_front();
          got = {blue_out, green_out, red_out};
          for (int i = 0; i < NUM_CH; i++) begin
            if (got[i] !== want[i]) begin
              report_mismatch($sformatf("%s_out %0d, expected %0d",
                                        ch_name[i], got[i], want[i]));
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        px.pix = {blue_in, green_in, red_in};
        px.cov = coverage;
        px.masked = masked_mode;
        pixels_due.push_back(saturate_pixel(px));
      end
      n_due <= pixels_due.size();
    end
  end

endmodule

### tb/pixel_saturation_adjust_test.sv
// pixel_saturation_adjust_test: stimulus and verdict for pixel_saturation_adjust.
// Depends on psa_pkg, the block itself and psa_check, which does the predicting.
`timescale 1ns / 100ps

module pixel_saturation_adjust_test;
  import psa_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int PHASE_PIXELS = 90;
  localparam int DRAIN_CYCLES = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CH_W-1:0]    red_in = '0;
  logic [CH_W-1:0]    green_in = '0;
  logic [CH_W-1:0]    blue_in = '0;
  logic [CH_W-1:0]    coverage = '0;
  logic               masked_mode = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;

  int          fail_count;
  int          pixels_in_flight;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned open_left = 0;
  int unsigned burst_left = 0;

  pixel_saturation_adjust u_dut (.*);
  psa_check u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[pixel_saturation_adjust] ERROR");
      $finish;
    end
  end

  // most gaps short, a few long
  function automatic int unsigned gap_span();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // output side: an open stretch, then a stall stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      open_left = 0;
    end else if (open_left != 0) begin
      open_left--;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      open_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 6);
      stall_left = gap_span();
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 9);
    if (r < 2) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 5) return 0;
    return gap_span();
  endfunction

  function automatic item_t make_pixel(int r, int g, int b, int cov, bit masked);
    item_t px;
    px.pix = {CH_W'(b), CH_W'(g), CH_W'(r)};
    px.cov = CH_W'(cov);
    px.masked = masked;
    return px;
  endfunction

  function automatic item_t random_pixel();
    item_t       px;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    for (int i = 0; i < NUM_CH; i++) begin
      if (pick == 0) begin
        px.pix[i] = ($urandom_range(0, 1) != 0) ? CH_MAX : '0;
      end else begin
        px.pix[i] = CH_W'($urandom());
      end
    end
    px.masked = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      px.cov = '0;
    end else if (pick == 1) begin
      px.cov = CH_MAX;
    end else if (pick == 2) begin
      px.cov = CH_W'(1);
    end else begin
      px.cov = CH_W'($urandom());
    end
    return px;
  endfunction

  // returns at the edge where the transfer happened
  task automatic send_pixel(item_t px);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= px.pix[0];
    green_in <= px.pix[1];
    blue_in <= px.pix[2];
    coverage <= px.cov;
    masked_mode <= px.masked;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_batch(int n);
    repeat (n) send_pixel(random_pixel());
    in_valid <= 1'b0;
  endtask

  // wait for the pipe to empty before touching the registers
  task automatic quiesce();
    do @(posedge clk); while (pixels_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(logic [1:0] idx, bit wr, logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write all four registers, then read each back for the checker
  task automatic load_config(logic [PDATA_W-1:0] factor, logic [PDATA_W-1:0] wr,
                             logic [PDATA_W-1:0] wg, logic [PDATA_W-1:0] wb);
    reg_access(REG_FACTOR, 1'b1, factor);
    reg_access(REG_WEIGHT_R, 1'b1, wr);
    reg_access(REG_WEIGHT_G, 1'b1, wg);
    reg_access(REG_WEIGHT_B, 1'b1, wb);
    reg_access(REG_FACTOR, 1'b0, '0);
    reg_access(REG_WEIGHT_R, 1'b0, '0);
    reg_access(REG_WEIGHT_G, 1'b0, '0);
    reg_access(REG_WEIGHT_B, 1'b0, '0);
  endtask

  // sometimes set junk above the register width
  function automatic logic [PDATA_W-1:0] with_junk(int unsigned low, int w);
    if ($urandom_range(0, 3) == 0) begin
      return ($urandom() << w) | low;
    end
    return low;
  endfunction

  function automatic int unsigned pick_weight();
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(257, 511);
    end
    return $urandom_range(0, 256);
  endfunction

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset weights and identity gain
    send_pixel(make_pixel(0, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(255, 255, 255, 255, 1'b0));
    send_pixel(make_pixel(255, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(0, 255, 0, 0, 1'b0));
    send_pixel(make_pixel(0, 0, 255, 0, 1'b0));
    send_pixel(make_pixel(200, 30, 90, 0, 1'b1));
    send_pixel(make_pixel(200, 30, 90, 255, 1'b1));
    send_pixel(make_pixel(200, 30, 90, 1, 1'b1));
    send_pixel(make_pixel(17, 240, 128, 128, 1'b1));
    send_pixel(make_pixel(255, 255, 255, 0, 1'b1));
    send_pixel(make_pixel(0, 0, 0, 255, 1'b1));
    send_pixel(make_pixel(12, 200, 90, 0, 1'b0));
    send_pixel(make_pixel(128, 128, 128, 77, 1'b0));
    send_pixel(make_pixel(255, 0, 255, 170, 1'b1));
    random_batch(PHASE_PIXELS);

    quiesce();
    load_config(32'd0, 32'd77, 32'd150, 32'd29);          // greyscale
    random_batch(PHASE_PIXELS);
    quiesce();
    load_config(32'hFFFF_FFFF, 32'd85, 32'd86, 32'd85);   // factor at its max
    random_batch(PHASE_PIXELS);
    quiesce();
    load_config(32'd512, 32'd256, 32'd256, 32'd256);      // luma clamps at full scale
    random_batch(PHASE_PIXELS);
    quiesce();
    load_config(32'd300, 32'h0000_FFFF, 32'd511, 32'd511);
    random_batch(PHASE_PIXELS);
    quiesce();
    load_config(32'd128, 32'd0, 32'd0, 32'd0);            // luma always zero
    random_batch(PHASE_PIXELS);
    quiesce();
    load_config(32'd256, 32'd256, 32'd0, 32'd0);
    random_batch(PHASE_PIXELS);

    repeat (3) begin
      quiesce();
      load_config(with_junk($urandom_range(0, 1023), FACTOR_W),
                  with_junk(pick_weight(), WEIGHT_W),
                  with_junk(pick_weight(), WEIGHT_W),
                  with_junk(pick_weight(), WEIGHT_W));
      random_batch(PHASE_PIXELS);
    end

    quiesce();
    if (fail_count == 0) begin
      $display("[pixel_saturation_adjust] OK");
    end else begin
      $display("[pixel_saturation_adjust] ERROR");
    end
    $finish;
  end

endmodule
